### hw/rtl/cosr_pkg.sv
`timescale 1ns / 1ps

package cosr_pkg;

	localparam int CHUNK_W     = 7;
	localparam int COUNT_W     = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int CHUNK_RESET = 64;
	localparam int READ_LIMIT  = 64;
	localparam int Q_DEPTH     = 2;
	localparam int Q_AW        = 1;
	localparam int Q_CW        = 2;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		RES_NOTIFY = 2'd0,
		RES_SAMPLE = 2'd1,
		RES_EMPTY  = 2'd2
	} res_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHUNK_SIZE = 1'b0,
		REG_NOTIFY_EN  = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMMIT_A,
		ST_COMMIT_B,
		ST_NOTIFY,
		ST_READ,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [CHUNK_W-1:0] max_n;
	} req_t;

endpackage

### hw/rtl/cosr_in_if.sv
`timescale 1ns / 1ps

interface cosr_in_if #(
	parameter int SAMPLE_BITS = 12
) ();
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [SAMPLE_BITS-1:0]           sample_value;
	logic [cosr_pkg::CHUNK_W-1:0]     max_count;

	modport source (output valid, kind, sample_value, max_count, input ready);
	modport sink (input valid, kind, sample_value, max_count, output ready);
endinterface

### hw/rtl/cosr_out_if.sv
`timescale 1ns / 1ps

interface cosr_out_if #(
	parameter int SAMPLE_BITS = 12
) ();
	logic                         valid;
	logic                         ready;
	logic [1:0]                   result_kind;
	logic [SAMPLE_BITS-1:0]       data_out;
	logic [cosr_pkg::COUNT_W-1:0] count;
	logic                         last;

	modport source (output valid, result_kind, data_out, count, last, input ready);
	modport sink (input valid, result_kind, data_out, count, last, output ready);
endinterface

### hw/rtl/cosr_cfg_if.sv
`timescale 1ns / 1ps

interface cosr_cfg_if ();
	logic                           valid;
	logic                           ready;
	logic [cosr_pkg::CFG_IDX_W-1:0] index;
	logic [cosr_pkg::CHUNK_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/cosr_front.sv
`timescale 1ns / 1ps

module cosr_front #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	cosr_in_if.sink                in_ch,
	output logic                   head_valid,
	output cosr_pkg::req_t         head_req,
	output logic [SAMPLE_BITS-1:0] head_sample,
	input  logic                   pop
);

	cosr_pkg::req_t             req_mem [cosr_pkg::Q_DEPTH];
	logic [SAMPLE_BITS-1:0]     smp_mem [cosr_pkg::Q_DEPTH];
	logic [cosr_pkg::Q_AW-1:0]  wr_q;
	logic [cosr_pkg::Q_AW-1:0]  rd_q;
	logic [cosr_pkg::Q_CW-1:0]  cnt_q;
	cosr_pkg::req_t             req_in;
	logic                       push;
	logic                       take;

	always_comb begin
		req_in.op    = in_ch.kind ? cosr_pkg::OP_READ : cosr_pkg::OP_SAMPLE;
		req_in.max_n = (32'(in_ch.max_count) > cosr_pkg::READ_LIMIT)
			? cosr_pkg::CHUNK_W'(cosr_pkg::READ_LIMIT) : in_ch.max_count;
	end

	assign in_ch.ready = (cnt_q != cosr_pkg::Q_CW'(cosr_pkg::Q_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = (cnt_q != '0);
	assign take        = pop && head_valid;
	assign head_req    = req_mem[rd_q];
	assign head_sample = smp_mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (take) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			req_mem[wr_q] <= req_in;
			smp_mem[wr_q] <= in_ch.sample_value;
		end
	end

endmodule

### hw/rtl/cosr_back.sv
`timescale 1ns / 1ps

module cosr_back #(
	parameter int MAX_CHUNK       = 64,
	parameter int CHUNKS_PER_RING = 8,
	parameter int SAMPLE_BITS     = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	cosr_cfg_if.sink               cfg,
	input  logic                   head_valid,
	input  cosr_pkg::req_t         head_req,
	input  logic [SAMPLE_BITS-1:0] head_sample,
	output logic                   pop,
	cosr_out_if.source             out_ch
);

	localparam int DEPTH    = MAX_CHUNK * CHUNKS_PER_RING;
	localparam int PW       = $clog2(DEPTH);
	localparam int CAPW     = $clog2(DEPTH + 1);
	localparam int SW       = CAPW + 1;
	localparam int CW       = cosr_pkg::CHUNK_W;
	localparam int CS_RESET = (cosr_pkg::CHUNK_RESET < MAX_CHUNK)
		? cosr_pkg::CHUNK_RESET : MAX_CHUNK;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];

	cosr_pkg::state_t state_q;
	cosr_pkg::state_t state_d;

	logic [CW-1:0]   cs_q;
	logic            notify_q;
	logic [CAPW-1:0] cap_q;
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [PW-1:0]   avail_q;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   drop_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   rem_q;

	logic                   valid_s2;
	cosr_pkg::res_kind_t    kind_s2;
	logic [cosr_pkg::COUNT_W-1:0] count_s2;
	logic                   last_s2;
	logic                   mem_s2;
	logic [SAMPLE_BITS-1:0] rd_data_s2;

	logic                   out_valid_q;
	cosr_pkg::res_kind_t    out_kind_q;
	logic [SAMPLE_BITS-1:0] out_data_q;
	logic [cosr_pkg::COUNT_W-1:0] out_count_q;
	logic                   out_last_q;

	logic                   out_load;
	logic                   adv;
	logic                   push;
	cosr_pkg::res_kind_t    push_kind;
	logic [cosr_pkg::COUNT_W-1:0] push_count;
	logic                   push_last;
	logic                   push_mem;
	logic                   mem_we;

	logic [SW-1:0]   pos_sum;
	logic [PW-1:0]   pos;
	logic [CW-1:0]   fill_inc;
	logic            chunk_full;
	logic [SW-1:0]   free_w;
	logic            short_w;
	logic [CW-1:0]   drop_w;
	logic [PW-1:0]   avail_cm;
	logic [CW-1:0]   n_w;
	logic [SW-1:0]   rp_drop_sum;
	logic [PW-1:0]   rp_drop;
	logic [SW-1:0]   wp_cs_sum;
	logic [PW-1:0]   wp_cs;
	logic [PW-1:0]   rp_inc;
	logic [CW-1:0]   cs_v;
	logic            cs_wr;

	always_comb begin
		pos_sum    = SW'(wp_q) + SW'(fill_q);
		pos        = (pos_sum >= SW'(cap_q)) ? PW'(pos_sum - SW'(cap_q)) : PW'(pos_sum);
		fill_inc   = fill_q + 1'b1;
		chunk_full = (fill_inc == cs_q);

		free_w   = SW'(cap_q) - SW'(1) - SW'(avail_q);
		short_w  = (free_w < SW'(cs_q));
		drop_w   = short_w ? CW'(SW'(cs_q) - free_w) : '0;
		avail_cm = short_w ? PW'(SW'(cap_q) - SW'(1)) : PW'(SW'(avail_q) + SW'(cs_q));

		n_w = (SW'(avail_q) < SW'(head_req.max_n)) ? CW'(avail_q) : head_req.max_n;

		rp_drop_sum = SW'(rp_q) + SW'(drop_q);
		rp_drop     = (rp_drop_sum >= SW'(cap_q))
			? PW'(rp_drop_sum - SW'(cap_q)) : PW'(rp_drop_sum);
		wp_cs_sum   = SW'(wp_q) + SW'(cs_q);
		wp_cs       = (wp_cs_sum >= SW'(cap_q))
			? PW'(wp_cs_sum - SW'(cap_q)) : PW'(wp_cs_sum);
		rp_inc      = ((SW'(rp_q) + SW'(1)) >= SW'(cap_q)) ? '0 : rp_q + 1'b1;

		cs_v  = (32'(cfg.data) > MAX_CHUNK) ? CW'(MAX_CHUNK) : cfg.data;
		cs_wr = cfg.valid && (cosr_pkg::cfg_idx_t'(cfg.index) == cosr_pkg::REG_CHUNK_SIZE)
			&& (cfg.data != '0);
	end

	assign out_load = valid_s2 && (!out_valid_q || out_ch.ready);
	assign adv      = !valid_s2 || out_load;

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		push       = 1'b0;
		push_kind  = cosr_pkg::RES_NOTIFY;
		push_count = '0;
		push_last  = 1'b1;
		push_mem   = 1'b0;
		mem_we     = 1'b0;
		case (state_q)
			cosr_pkg::ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					if (head_req.op == cosr_pkg::OP_SAMPLE) begin
						mem_we = 1'b1;
						if (chunk_full) begin
							state_d = cosr_pkg::ST_COMMIT_A;
						end
					end else if (n_w == '0) begin
						state_d = cosr_pkg::ST_EMPTY;
					end else begin
						state_d = cosr_pkg::ST_READ;
					end
				end
			end
			cosr_pkg::ST_COMMIT_A: begin
				state_d = cosr_pkg::ST_COMMIT_B;
			end
			cosr_pkg::ST_COMMIT_B: begin
				state_d = notify_q ? cosr_pkg::ST_NOTIFY : cosr_pkg::ST_IDLE;
			end
			cosr_pkg::ST_NOTIFY: begin
				if (adv) begin
					push       = 1'b1;
					push_kind  = cosr_pkg::RES_NOTIFY;
					push_count = cosr_pkg::COUNT_W'(avail_q);
					state_d    = cosr_pkg::ST_IDLE;
				end
			end
			cosr_pkg::ST_EMPTY: begin
				if (adv) begin
					push      = 1'b1;
					push_kind = cosr_pkg::RES_EMPTY;
					state_d   = cosr_pkg::ST_IDLE;
				end
			end
			cosr_pkg::ST_READ: begin
				if (adv) begin
					push       = 1'b1;
					push_kind  = cosr_pkg::RES_SAMPLE;
					push_count = cosr_pkg::COUNT_W'(n_q);
					push_last  = (rem_q == CW'(1));
					push_mem   = 1'b1;
					if (rem_q == CW'(1)) begin
						state_d = cosr_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = cosr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cosr_pkg::ST_IDLE;
			cs_q        <= CW'(CS_RESET);
			cap_q       <= CAPW'(CS_RESET * CHUNKS_PER_RING);
			notify_q    <= 1'b1;
			wp_q        <= '0;
			rp_q        <= '0;
			avail_q     <= '0;
			fill_q      <= '0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				fill_q <= chunk_full ? '0 : fill_inc;
			end
			if (state_q == cosr_pkg::ST_COMMIT_A) begin
				avail_q <= avail_cm;
			end
			if (state_q == cosr_pkg::ST_COMMIT_B) begin
				rp_q <= rp_drop;
				wp_q <= wp_cs;
			end
			if (push && push_mem) begin
				rp_q    <= rp_inc;
				avail_q <= avail_q - 1'b1;
			end
			if (adv) begin
				valid_s2 <= push;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cs_wr) begin
				cs_q    <= cs_v;
				cap_q   <= CAPW'(32'(cs_v) * CHUNKS_PER_RING);
				wp_q    <= '0;
				rp_q    <= '0;
				avail_q <= '0;
				fill_q  <= '0;
			end
			if (cfg.valid && (cosr_pkg::cfg_idx_t'(cfg.index) == cosr_pkg::REG_NOTIFY_EN)) begin
				notify_q <= cfg.data[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pos] <= head_sample;
		end
		if (push && push_mem) begin
			rd_data_s2 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_req.op == cosr_pkg::OP_READ) begin
			n_q   <= n_w;
			rem_q <= n_w;
		end else if (push && push_mem) begin
			rem_q <= rem_q - 1'b1;
		end
		if (state_q == cosr_pkg::ST_COMMIT_A) begin
			drop_q <= drop_w;
		end
		if (push) begin
			kind_s2  <= push_kind;
			count_s2 <= push_count;
			last_s2  <= push_last;
			mem_s2   <= push_mem;
		end
		if (out_load) begin
			out_kind_q  <= kind_s2;
			out_data_q  <= mem_s2 ? rd_data_s2 : '0;
			out_count_q <= count_s2;
			out_last_q  <= last_s2;
		end
	end

	assign cfg.ready          = 1'b1;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_kind = out_kind_q;
	assign out_ch.data_out    = out_data_q;
	assign out_ch.count       = out_count_q;
	assign out_ch.last        = out_last_q;

endmodule

### hw/rtl/chunked_overwrite_sample_ring_core.sv
`timescale 1ns / 1ps
// Sample ring of CHUNKS_PER_RING chunks with overwrite of the oldest data.
// The in_ch channel carries sample requests (kind 0) and read requests (kind 1).
// Requests enter a two-entry queue and are executed one at a time by a sequencer
// that owns the pointers and the sample memory.
// A sample request writes its sample; when it completes a chunk, the commit
// passes ST_COMMIT_A and ST_COMMIT_B, then the optional notification on out_ch.
// A read request of n samples passes a setup step and then streams n results
// at one per cycle unless out_ch stalls; an empty read gives one result with
// result_kind 2. Results pass a memory read register and an output register.
// When out_ch is stalled the sequencer waits and in_ch fills the queue, after
// which in_ch.ready drops.
// Reset clears the pointers, sets chunk_size to min(64, MAX_CHUNK) and enables
// notifications. The sample memory is not cleared; only committed entries are
// ever read. The cfg channel is always ready; writing a nonzero chunk_size
// empties the ring, and it may only be written while no request is in flight.

module chunked_overwrite_sample_ring_core #(
	parameter int MAX_CHUNK       = 64,
	parameter int CHUNKS_PER_RING = 8,
	parameter int SAMPLE_BITS     = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	cosr_in_if.sink    in_ch,
	cosr_out_if.source out_ch,
	cosr_cfg_if.sink   cfg
);

	logic                   head_valid;
	cosr_pkg::req_t         head_req;
	logic [SAMPLE_BITS-1:0] head_sample;
	logic                   pop;

	cosr_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.head_valid (head_valid),
		.head_req   (head_req),
		.head_sample(head_sample),
		.pop        (pop)
	);

	cosr_back #(
		.MAX_CHUNK      (MAX_CHUNK),
		.CHUNKS_PER_RING(CHUNKS_PER_RING),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_req   (head_req),
		.head_sample(head_sample),
		.pop        (pop),
		.out_ch     (out_ch)
	);

`ifndef ASSERT_OFF
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_notify_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.result_kind == cosr_pkg::RES_NOTIFY)
		|-> (out_ch.last && out_ch.data_out == '0))
		else $error("notification carries data or is not last");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.result_kind == cosr_pkg::RES_EMPTY)
		|-> (out_ch.last && out_ch.count == '0 && out_ch.data_out == '0))
		else $error("empty read result malformed");

	a_sample_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.result_kind == cosr_pkg::RES_SAMPLE && !out_ch.last)
		|-> (out_ch.count > 1))
		else $error("non-final sample result with count below two");
`endif

endmodule
